### rtl/led_frm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frm_pkg
// Shared types, constants and tables of the LED display frame composer.
// ----------------------------------------------------------------------------
package led_frm_pkg;

    localparam int FRAME_BYTES_DEF = 27;

    localparam int OPC_W  = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 14;
    localparam int COL_W  = 3;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;
    localparam int DIG_W  = 4;

    localparam logic [BYTE_W-1:0] COLOR_BLACK = 8'hE0;
    localparam logic [IDX_W-1:0]  DIGIT_BASE  = 5'd17;
    localparam logic [IDX_W-1:0]  ROW1_BASE   = 5'd22;
    localparam logic [POS_W-1:0]  MARK_MAX    = 5'd16;
    localparam logic [POS_W-1:0]  DIGIT_MAX   = 5'd9;
    localparam logic [POS_W-1:0]  ROW_MAX     = 5'd1;
    localparam logic [VAL_W-1:0]  SYMBOL_MAX  = 14'd63;
    localparam logic [VAL_W-1:0]  NUMBER_MAX  = 14'd9999;

    typedef enum logic [OPC_W-1:0] {
        OP_SET_MARK   = 3'd0,
        OP_SET_DIGIT  = 3'd1,
        OP_SET_NUMBER = 3'd2,
        OP_CLEAR_SEND = 3'd3,
        OP_SEND       = 3'd4
    } t_opcode;

    // Access request from the sequencer to the frame store.
    typedef struct packed {
        logic              clr;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_store_req;

    function automatic logic [BYTE_W-1:0] color_code(input logic [COL_W-1:0] idx);
        logic [BYTE_W-1:0] code;
        case (idx)
            3'd0:    code = 8'hE0;
            3'd1:    code = 8'h00;
            3'd2:    code = 8'h20;
            3'd3:    code = 8'h40;
            3'd4:    code = 8'h60;
            3'd5:    code = 8'h80;
            3'd6:    code = 8'hA0;
            default: code = 8'hC0;
        endcase
        return code;
    endfunction

    // Place weight: thousands, hundreds, tens, units.
    function automatic logic [VAL_W-1:0] place_weight(input logic [1:0] place);
        logic [VAL_W-1:0] w;
        case (place)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/led_frm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frm_if
// Valid/ready channels of the frame composer: command words in, frame
// byte words out.
// ----------------------------------------------------------------------------
interface led_frm_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [led_frm_pkg::OPC_W-1:0]   opcode;
    logic [led_frm_pkg::POS_W-1:0]   position;
    logic [led_frm_pkg::VAL_W-1:0]   value;
    logic [led_frm_pkg::COL_W-1:0]   color;

    modport source (output valid, opcode, position, value, color, input ready);
    modport sink   (input valid, opcode, position, value, color, output ready);
endinterface

interface led_frm_byte_if;
    logic                            valid;
    logic                            ready;
    logic [led_frm_pkg::BYTE_W-1:0]  frame_byte;
    logic [led_frm_pkg::IDX_W-1:0]   byte_index;
    logic                            last_byte;

    modport source (output valid, frame_byte, byte_index, last_byte, input ready);
    modport sink   (input valid, frame_byte, byte_index, last_byte, output ready);
endinterface

`default_nettype wire

### rtl/led_display_frame_composer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_display_frame_composer_unit
// Keeps the 27-byte frame of a colored LED display, edits it on command
// and streams it out byte by byte.
// ----------------------------------------------------------------------------
// Timing: set mark and set digit write the store in the cycle in which the
// word is taken; the block is ready again right after. Set number then stays
// busy while one shared subtract-and-compare unit peels each digit off by
// repeated subtraction of its place weight. Send and clear-and-send then keep
// the block busy while the frame store's single registered read port yields
// one byte per cycle, as long as the output side does not hold back the
// stream. The command channel is not ready while a number is converted or a
// frame is streamed.
// The output register decouples the two sides, so the last word of a frame
// may still wait while the next command is taken. Reset and clear act at
// once through per-byte valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module led_display_frame_composer_unit #(
    parameter int FRAME_BYTES = led_frm_pkg::FRAME_BYTES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    led_frm_cmd_if.sink     i_cmd,
    led_frm_byte_if.source  o_byte
);
    import led_frm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SEND
    } t_state;

    t_state            r_state,   n_state;
    // number conversion
    logic [VAL_W-1:0]  r_rem,     n_rem;
    logic [1:0]        r_place,   n_place;
    logic [DIG_W-1:0]  r_digit,   n_digit;
    logic              r_lead,    n_lead;
    logic [IDX_W-1:0]  r_base,    n_base;
    logic [BYTE_W-1:0] r_col,     n_col;
    // streaming
    logic              r_issuing, n_issuing;
    logic [IDX_W-1:0]  r_idx,     n_idx;
    logic              r_pend,    n_pend;
    logic [IDX_W-1:0]  r_pidx,    n_pidx;
    // output register
    logic              r_ov,      n_ov;
    logic [BYTE_W-1:0] r_obyte,   n_obyte;
    logic [IDX_W-1:0]  r_oidx,    n_oidx;
    logic              r_olast,   n_olast;

    t_store_req        req;
    logic [BYTE_W-1:0] rdata;

    logic              cmd_acc;
    logic [BYTE_W-1:0] cmd_col;
    logic [VAL_W:0]    diff;
    logic              out_free;
    logic              load;
    logic              rd_en;

    led_frm_store #(
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata)
    );

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign cmd_acc           = i_cmd.valid && i_cmd.ready;
    assign cmd_col           = color_code(i_cmd.color);

    assign o_byte.valid      = r_ov;
    assign o_byte.frame_byte = r_obyte;
    assign o_byte.byte_index = r_oidx;
    assign o_byte.last_byte  = r_olast;

    // Shared unit: trial subtraction of the current place weight.
    assign diff = {1'b0, r_rem} - {1'b0, place_weight(r_place)};

    // Read data moves to the output register once that register frees up.
    assign out_free = !r_ov || o_byte.ready;
    assign load     = r_pend && out_free;
    assign rd_en    = (r_state == S_SEND) && r_issuing && (!r_pend || load);

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_place   = r_place;
        n_digit   = r_digit;
        n_lead    = r_lead;
        n_base    = r_base;
        n_col     = r_col;
        n_issuing = r_issuing;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_ov      = r_ov && !o_byte.ready;
        n_obyte   = r_obyte;
        n_oidx    = r_oidx;
        n_olast   = r_olast;

        req       = '0;
        req.re    = rd_en;
        req.raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.opcode)
                        OP_SET_MARK: begin
                            if (i_cmd.position <= MARK_MAX) begin
                                req.we    = 1'b1;
                                req.waddr = i_cmd.position;
                                req.wdata = cmd_col;
                            end
                        end
                        OP_SET_DIGIT: begin
                            if (i_cmd.position <= DIGIT_MAX && i_cmd.value <= SYMBOL_MAX) begin
                                req.we    = 1'b1;
                                req.waddr = DIGIT_BASE + i_cmd.position;
                                req.wdata = cmd_col + {2'b00, i_cmd.value[5:0]};
                            end
                        end
                        OP_SET_NUMBER: begin
                            if (i_cmd.position <= ROW_MAX && i_cmd.value <= NUMBER_MAX) begin
                                n_rem   = i_cmd.value;
                                n_place = 2'd0;
                                n_digit = '0;
                                n_lead  = 1'b1;
                                n_base  = i_cmd.position[0] ? ROW1_BASE : DIGIT_BASE;
                                n_col   = cmd_col;
                                n_state = S_CONV;
                            end
                        end
                        OP_CLEAR_SEND: begin
                            req.clr   = 1'b1;
                            n_issuing = 1'b1;
                            n_idx     = '0;
                            n_state   = S_SEND;
                        end
                        OP_SEND: begin
                            n_issuing = 1'b1;
                            n_idx     = '0;
                            n_state   = S_SEND;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_CONV: begin
                if (!diff[VAL_W]) begin
                    // weight still fits: count one more in this place
                    n_rem   = diff[VAL_W-1:0];
                    n_digit = r_digit + 1'b1;
                end else begin
                    req.we    = 1'b1;
                    req.waddr = r_base + {3'b000, r_place};
                    if (r_lead && r_digit == '0 && r_place != 2'd3) begin
                        req.wdata = COLOR_BLACK;
                    end else begin
                        req.wdata = r_col + {4'b0000, r_digit};
                    end
                    n_lead  = r_lead && (r_digit == '0);
                    n_place = r_place + 1'b1;
                    n_digit = '0;
                    if (r_place == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_SEND: begin
                if (rd_en) begin
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end
                end
                n_pend = rd_en || (r_pend && !load);
                if (load) begin
                    n_ov    = 1'b1;
                    n_obyte = rdata;
                    n_oidx  = r_pidx;
                    n_olast = (r_pidx == LAST_IDX);
                    if (r_pidx == LAST_IDX) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_place <= n_place;
        r_digit <= n_digit;
        r_lead  <= n_lead;
        r_base  <= n_base;
        r_col   <= n_col;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_obyte <= n_obyte;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_pend    <= n_pend;
            r_ov      <= n_ov;
        end
    end

endmodule

`default_nettype wire

### rtl/led_frm_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frm_store
// Frame byte memory: one write and one registered read per cycle, with a
// valid bit per byte so that reset and clear show black at once.
// ----------------------------------------------------------------------------
module led_frm_store #(
    parameter int DEPTH = led_frm_pkg::FRAME_BYTES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  led_frm_pkg::t_store_req          i_req,
    output logic [led_frm_pkg::BYTE_W-1:0]   o_rdata
);
    import led_frm_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [BYTE_W-1:0] r_rdata;

    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign waddr   = i_req.waddr[ADDR_W-1:0];
    assign raddr   = i_req.raddr[ADDR_W-1:0];
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_vld[raddr] ? r_mem[raddr] : COLOR_BLACK;
        end
    end

    // Drop all bytes back to black on reset or clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[waddr] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/led_frm_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_frm_chk
// Port-level checks of the frame composer, bound to the top level.
// ----------------------------------------------------------------------------
module led_frm_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_cmd_ready,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [led_frm_pkg::BYTE_W-1:0]    i_out_byte,
    input wire [led_frm_pkg::IDX_W-1:0]     i_out_idx,
    input wire                              i_out_last
);
    import led_frm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES_DEF - 1);

    // Flag the last word exactly at the final byte position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_idx == LAST_IDX)))
        else $error("last_byte does not match byte_index");

    // Advance the byte index by one from word to word within a frame.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (!i_out_valid || i_out_idx == $past(i_out_idx) + 1'b1))
        else $error("byte_index skipped or repeated");

    // Hold off commands while a frame is still being streamed.
    a_busy_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_cmd_ready)
        else $error("command taken in the middle of a frame");

    // Hold a stalled word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_idx)
             && $stable(i_out_last)))
        else $error("stalled output word changed");

endmodule

bind led_display_frame_composer_unit led_frm_chk u_led_frm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.frame_byte),
    .i_out_idx   (o_byte.byte_index),
    .i_out_last  (o_byte.last_byte)
);

`default_nettype wire

### dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the LED display frame composer. A short table of
// commands walks the extremes, the out-of-range and spare cases, then a
// random command stream runs with idle gaps on both channels, one long
// output hold-off and three full drains. Every streamed frame byte is checked
// against an in-bench copy of the frame.
// ----------------------------------------------------------------------------
module tb;
    import led_frm_pkg::*;

    localparam int FRAME_LEN     = FRAME_BYTES_DEF;
    localparam int RAND_WORDS    = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 60;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int REPORT_MAX    = 10;
    localparam int PLAN_LEN      = 26;

    // Opcodes that the block must take and ignore.
    localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

    // One frame byte word as it should leave the block.
    typedef struct {
        logic [BYTE_W-1:0] fbyte;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_frame_word;

    // One row of the directed plan. When known is set, every byte of the
    // streamed frame must equal fill.
    typedef struct packed {
        logic [OPC_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic [COL_W-1:0]  col;
        logic              known;
        logic [BYTE_W-1:0] fill;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    led_frm_cmd_if  cmd_if ();
    led_frm_byte_if byte_if ();

    led_display_frame_composer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_byte  (byte_if)
    );

    // Shadow copy of the display frame and the bytes still owed by the block.
    logic [BYTE_W-1:0] frame_img [FRAME_LEN];
    t_frame_word       bytes_due [$];
    int                mismatch_cnt;
    int                idle_cnt;

    // Receiver pacing.
    logic hold_off_req;
    logic hold_done;
    int   stall_left;
    int   burst_left;
    int   rx_gap;

    t_plan_row directed_plan [PLAN_LEN];

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Colour code: black is special, the rest step by 0x20 from white at 0x00.
    function automatic logic [BYTE_W-1:0] tint(input logic [COL_W-1:0] col);
        return (col == 3'd0) ? COLOR_BLACK : {col - 3'd1, 5'd0};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Apply one accepted command word to the shadow frame and queue the bytes
    // it streams. A known fill overrides the shadow bytes for table rows whose
    // result is obvious.
    task automatic compose_frame(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val, input logic [COL_W-1:0] col,
                                 input logic known, input logic [BYTE_W-1:0] fill);
        logic [BYTE_W-1:0] shade;
        logic [IDX_W-1:0]  base;
        t_frame_word       w;
        shade = tint(col);
        case (op)
            OP_SET_MARK: begin
                if (pos <= MARK_MAX) frame_img[pos] = shade;
            end
            OP_SET_DIGIT: begin
                if (pos <= DIGIT_MAX && val <= SYMBOL_MAX)
                    frame_img[DIGIT_BASE + pos] = shade + val[BYTE_W-1:0];
            end
            OP_SET_NUMBER: begin
                if (pos <= ROW_MAX && val <= NUMBER_MAX) begin
                    base = (pos == 5'd0) ? DIGIT_BASE : ROW1_BASE;
                    // Blank leading zeros; the units place always shows.
                    frame_img[base]        = (val > 999) ? shade + 8'(val / 1000)
                                                         : COLOR_BLACK;
                    frame_img[base + 5'd1] = (val > 99)  ? shade + 8'((val % 1000) / 100)
                                                         : COLOR_BLACK;
                    frame_img[base + 5'd2] = (val > 9)   ? shade + 8'((val % 100) / 10)
                                                         : COLOR_BLACK;
                    frame_img[base + 5'd3] = shade + 8'(val % 10);
                end
            end
            OP_CLEAR_SEND, OP_SEND: begin
                if (op == OP_CLEAR_SEND) begin
                    for (int k = 0; k < FRAME_LEN; k++) frame_img[k] = COLOR_BLACK;
                end
                for (int k = 0; k < FRAME_LEN; k++) begin
                    w.fbyte = known ? fill : frame_img[k];
                    w.idx   = IDX_W'(k);
                    w.last  = (k == FRAME_LEN - 1);
                    bytes_due.push_back(w);
                end
            end
            default: ; // spare opcodes leave the frame alone
        endcase
    endtask

    // Offer one command word, hold it until taken, then predict its effect.
    task automatic push_command(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input logic [COL_W-1:0] col,
                                input logic known, input logic [BYTE_W-1:0] fill);
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.position <= pos;
        cmd_if.value    <= val;
        cmd_if.color    <= col;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        compose_frame(op, pos, val, col, known, fill);
    endtask

    // Drop valid for the given gap; a zero gap keeps valid high into the next word.
    task automatic sender_gap(input int n);
        if (n > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering words until every owed byte has come out.
    task automatic drain_frames();
        cmd_if.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with stalls and bursts, plus one long hold-off
    // on request from the stimulus.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.ready <= 1'b0;
            stall_left    <= 0;
            burst_left    <= 0;
            hold_done     <= 1'b0;
        end else if (hold_off_req && !hold_done) begin
            // Hold ready low long enough for the block to back up into its input.
            hold_done     <= 1'b1;
            byte_if.ready <= 1'b0;
            stall_left    <= HOLD_CYCLES;
        end else if (stall_left != 0) begin
            byte_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (burst_left != 0) begin
            byte_if.ready <= 1'b1;
            burst_left    <= burst_left - 1;
        end else begin
            rx_gap = idle_gap();
            byte_if.ready <= (rx_gap == 0);
            stall_left    <= (rx_gap == 0) ? 0 : rx_gap - 1;
            burst_left    <= $urandom_range(0, 40);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each taken frame byte word with the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_word want;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            if (bytes_due.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected frame byte %h index %0d last %b",
                             byte_if.frame_byte, byte_if.byte_index, byte_if.last_byte);
            end else begin
                want = bytes_due.pop_front();
                if (byte_if.frame_byte !== want.fbyte || byte_if.byte_index !== want.idx ||
                    byte_if.last_byte !== want.last) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("frame byte mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 want.fbyte, want.idx, want.last, byte_if.frame_byte,
                                 byte_if.byte_index, byte_if.last_byte);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (byte_if.valid && byte_if.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_MAX) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int               roll;
        int               span;
        logic [OPC_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [COL_W-1:0] col;

        // Drive every block input to a known value from time zero.
        i_rst_n          <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.opcode    <= OP_SET_MARK;
        cmd_if.position  <= '0;
        cmd_if.value     <= '0;
        cmd_if.color     <= '0;
        hold_off_req     <= 1'b0;
        for (int k = 0; k < FRAME_LEN; k++) frame_img[k] = COLOR_BLACK;

        // Directed plan: extremes, out-of-range arguments, spare opcodes,
        // digit wrap past 0xFF, blanking of leading zeros, clear.
        directed_plan = '{
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b1, COLOR_BLACK}, // frame after reset
            '{OP_SET_MARK,   5'd0,  14'd0,     3'd1, 1'b0, 8'h00},
            '{OP_SET_MARK,   5'd16, 14'd16383, 3'd7, 1'b0, 8'h00},
            '{OP_SET_MARK,   5'd17, 14'd0,     3'd2, 1'b0, 8'h00},      // mark out of range
            '{OP_SET_MARK,   5'd31, 14'd16383, 3'd3, 1'b0, 8'h00},      // top position
            '{OP_SET_DIGIT,  5'd0,  14'd0,     3'd0, 1'b0, 8'h00},
            '{OP_SET_DIGIT,  5'd9,  14'd63,    3'd7, 1'b0, 8'h00},
            '{OP_SET_DIGIT,  5'd5,  14'd63,    3'd0, 1'b0, 8'h00},      // wraps past 0xFF
            '{OP_SET_DIGIT,  5'd10, 14'd5,     3'd1, 1'b0, 8'h00},      // digit index too big
            '{OP_SET_DIGIT,  5'd3,  14'd64,    3'd1, 1'b0, 8'h00},      // symbol too big
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b0, 8'h00},
            '{OP_SET_NUMBER, 5'd0,  14'd9999,  3'd2, 1'b0, 8'h00},
            '{OP_SET_NUMBER, 5'd1,  14'd0,     3'd4, 1'b0, 8'h00},      // all leading blanks
            '{OP_SET_NUMBER, 5'd0,  14'd10000, 3'd5, 1'b0, 8'h00},      // number too big
            '{OP_SET_NUMBER, 5'd2,  14'd5,     3'd6, 1'b0, 8'h00},      // row out of range
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b0, 8'h00},
            '{OP_SET_NUMBER, 5'd1,  14'd1000,  3'd6, 1'b0, 8'h00},
            '{OP_SET_NUMBER, 5'd0,  14'd99,    3'd3, 1'b0, 8'h00},
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b0, 8'h00},
            '{OP_SPARE_LO,   5'd31, 14'd16383, 3'd7, 1'b0, 8'h00},
            '{OP_SPARE_HI,   5'd0,  14'd0,     3'd0, 1'b0, 8'h00},
            '{OP_CLEAR_SEND, 5'd3,  14'd77,    3'd5, 1'b1, COLOR_BLACK}, // all black
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b1, COLOR_BLACK},
            '{OP_SET_NUMBER, 5'd0,  14'd16383, 3'd1, 1'b0, 8'h00},      // top value ignored
            '{OP_SET_NUMBER, 5'd1,  14'd10,    3'd7, 1'b0, 8'h00},
            '{OP_SEND,       5'd0,  14'd0,     3'd0, 1'b0, 8'h00}
        };

        // Hold reset once at the start, then release it.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r]) begin
            push_command(directed_plan[r].op, directed_plan[r].pos, directed_plan[r].val,
                         directed_plan[r].col, directed_plan[r].known,
                         directed_plan[r].fill);
            sender_gap(idle_gap());
        end
        drain_frames();

        // Random stream: mostly well-formed commands with random content,
        // the rest spare opcodes and out-of-range arguments.
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == 60) begin
                // Hold off the receiver and keep offering sends back to back
                // so the output side backs up into the command channel.
                hold_off_req <= 1'b1;
                for (int s = 0; s < 4; s++)
                    push_command(OP_SEND, '0, '0, '0, 1'b0, 8'h00);
            end
            if (n == 130) drain_frames();

            roll = $urandom_range(0, 99);
            col  = COL_W'($urandom_range(0, 7));
            pos  = '0;
            val  = '0;
            if (roll < 25) begin
                op  = OP_SET_MARK;
                pos = POS_W'($urandom_range(0, MARK_MAX));
                val = VAL_W'($urandom_range(0, 16383));
            end else if (roll < 45) begin
                op  = OP_SET_DIGIT;
                pos = POS_W'($urandom_range(0, DIGIT_MAX));
                val = VAL_W'($urandom_range(0, SYMBOL_MAX));
            end else if (roll < 65) begin
                op   = OP_SET_NUMBER;
                pos  = POS_W'($urandom_range(0, ROW_MAX));
                // Spread over one to four digits so each blanking case shows.
                span = $urandom_range(0, 3);
                case (span)
                    0:       val = VAL_W'($urandom_range(0, 9));
                    1:       val = VAL_W'($urandom_range(10, 99));
                    2:       val = VAL_W'($urandom_range(100, 999));
                    default: val = VAL_W'($urandom_range(1000, NUMBER_MAX));
                endcase
            end else if (roll < 78) begin
                op = OP_SEND;
            end else if (roll < 83) begin
                op  = OP_CLEAR_SEND;
                pos = POS_W'($urandom_range(0, 31));
            end else if (roll < 88) begin
                op  = OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                pos = POS_W'($urandom_range(0, 31));
                val = VAL_W'($urandom_range(0, 16383));
            end else begin
                // Broken set command: arguments mostly out of range.
                roll = $urandom_range(0, 2);
                case (roll)
                    0:       op = OP_SET_MARK;
                    1:       op = OP_SET_DIGIT;
                    default: op = OP_SET_NUMBER;
                endcase
                pos = POS_W'($urandom_range(0, 31));
                val = VAL_W'($urandom_range(0, 16383));
            end

            push_command(op, pos, val, col, 1'b0, 8'h00);
            // Keep some stretches free of gaps.
            sender_gap((n % 40 < 10) ? 0 : idle_gap());
        end

        drain_frames();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (bytes_due.size() != 0) begin
            $display("%0d frame bytes never came out", bytes_due.size());
        end
        if (mismatch_cnt == 0 && bytes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
